@@ design/rqop_pkg.sv @@
// Shared constants, codes and types for the request queue overload policy block.
package rqop_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int INDEX_W     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = 5;
   localparam int TAG_W       = 16;
   localparam int CMD_W       = 2;
   localparam int KIND_W      = 3;
   localparam int MODE_W      = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CMD_W-1:0] CMD_ARRIVE   = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_DISPATCH = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_COMPLETE = CMD_W'(2);

   localparam logic [KIND_W-1:0] EV_QUEUED     = KIND_W'(0);
   localparam logic [KIND_W-1:0] EV_DROPPED    = KIND_W'(1);
   localparam logic [KIND_W-1:0] EV_EVICTED    = KIND_W'(2);
   localparam logic [KIND_W-1:0] EV_DISPATCHED = KIND_W'(3);
   localparam logic [KIND_W-1:0] EV_RETRY      = KIND_W'(4);
   localparam logic [KIND_W-1:0] EV_EMPTY      = KIND_W'(5);
   localparam logic [KIND_W-1:0] EV_DONE       = KIND_W'(6);
   localparam logic [KIND_W-1:0] EV_ERROR      = KIND_W'(7);

   localparam logic [MODE_W-1:0] MODE_BLOCK     = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_DROP_TAIL = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_DROP_HEAD = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_DROP_HALF = MODE_W'(3);

   localparam logic [CSR_INDEX_W-1:0] CSR_QUEUE_LIMIT   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_OVERLOAD_MODE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_WORKER_COUNT  = CSR_INDEX_W'(2);

   localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET  = COUNT_W'(16);
   localparam logic [MODE_W-1:0]  MODE_RESET         = MODE_BLOCK;
   localparam logic [COUNT_W-1:0] WORKER_COUNT_RESET = COUNT_W'(4);

   typedef struct packed {
      logic [COUNT_W-1:0] queue_limit;
      logic [MODE_W-1:0]  overload_mode;
      logic [COUNT_W-1:0] worker_count;
   } cfg_type;

   typedef struct packed {
      logic               we;
      logic [INDEX_W-1:0] waddr;
      logic [TAG_W-1:0]   wdata;
      logic [INDEX_W-1:0] raddr;
   } ring_ctl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] waiting;
      logic [COUNT_W-1:0] busy;
   } status_type;

endpackage

@@ design/rqop_ifs.sv @@
// Valid/ready channel interfaces for requests and responses.
interface rqop_req_if;
   import rqop_pkg::*;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] cmd;
   logic [TAG_W-1:0] conn_tag;
   modport source (output valid, cmd, conn_tag, input ready);
   modport sink (input valid, cmd, conn_tag, output ready);
endinterface

interface rqop_rsp_if;
   import rqop_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  event_kind;
   logic [TAG_W-1:0]   out_tag;
   logic [COUNT_W-1:0] waiting_now;
   logic [COUNT_W-1:0] busy_now;
   logic               last;
   modport source (output valid, event_kind, out_tag, waiting_now, busy_now, last, input ready);
   modport sink (input valid, event_kind, out_tag, waiting_now, busy_now, last, output ready);
endinterface

@@ design/rqop_tag_ring.sv @@
// Tag ring storage: one write port and one read port with registered read data.
module rqop_tag_ring (
   input  logic                  clock,
   input  rqop_pkg::ring_ctl_type ring_ctl,
   output logic [rqop_pkg::TAG_W-1:0] rd_data
);
   import rqop_pkg::*;

   logic [TAG_W-1:0] tag_mem [QUEUE_DEPTH];
   logic [TAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ring_ctl.we) begin
         tag_mem[ring_ctl.waddr] <= ring_ctl.wdata;
      end
      rd_data_ff <= tag_mem[ring_ctl.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/rqop_engine.sv @@
// Admission control sequencer with queue counters and the response output register.
module rqop_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  rqop_pkg::cfg_type          cfg,
   rqop_req_if.sink                   req_chan,
   rqop_rsp_if.source                 rsp_chan,
   output rqop_pkg::ring_ctl_type     ring_ctl,
   input  logic [rqop_pkg::TAG_W-1:0] rd_data,
   output rqop_pkg::status_type       status
);
   import rqop_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EXEC  = 4'b0010,
      ST_EVICT = 4'b0100,
      ST_PUSH  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CMD_W-1:0]   cmd_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [INDEX_W-1:0] head_ff, head_in;
   logic [COUNT_W-1:0] waiting_ff, waiting_in;
   logic [COUNT_W-1:0] busy_ff, busy_in;
   logic [COUNT_W-1:0] left_ff, left_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [TAG_W-1:0]   out_tag_ff;
   logic [COUNT_W-1:0] waiting_now_ff;
   logic [COUNT_W-1:0] busy_now_ff;
   logic               last_ff;

   logic               out_free;
   logic               emit;
   logic [KIND_W-1:0]  ev_kind;
   logic [TAG_W-1:0]   ev_tag;
   logic               ev_last;
   logic               ring_we;
   logic [COUNT_W:0]   load;
   logic               full;
   logic [COUNT_W-1:0] half_count;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign load       = {1'b0, waiting_ff} + {1'b0, busy_ff};
   assign full       = load >= {1'b0, cfg.queue_limit};
   assign half_count = COUNT_W'(({1'b0, waiting_ff} + (COUNT_W + 1)'(1)) >> 1);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      waiting_in = waiting_ff;
      busy_in    = busy_ff;
      left_in    = left_ff;
      emit       = 1'b0;
      ev_kind    = EV_ERROR;
      ev_tag     = '0;
      ev_last    = 1'b1;
      ring_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               unique case (cmd_ff)
                  CMD_ARRIVE: begin
                     ev_tag = tag_ff;
                     if (busy_ff == cfg.queue_limit) begin
                        ev_kind = EV_DROPPED;
                     end else if (full && waiting_ff != '0) begin
                        case (cfg.overload_mode)
                           MODE_BLOCK: begin
                              ev_kind = EV_RETRY;
                           end
                           MODE_DROP_HEAD: begin
                              head_in    = head_ff + INDEX_W'(1);
                              waiting_in = waiting_ff - COUNT_W'(1);
                              ev_kind    = EV_EVICTED;
                              ev_tag     = rd_data;
                              ev_last    = 1'b0;
                              state_in   = ST_PUSH;
                           end
                           MODE_DROP_HALF: begin
                              head_in    = head_ff + INDEX_W'(1);
                              waiting_in = waiting_ff - COUNT_W'(1);
                              ev_kind    = EV_EVICTED;
                              ev_tag     = rd_data;
                              ev_last    = 1'b0;
                              left_in    = half_count - COUNT_W'(1);
                              state_in   = (half_count == COUNT_W'(1)) ? ST_PUSH : ST_EVICT;
                           end
                           default: begin
                              ev_kind = EV_DROPPED;
                           end
                        endcase
                     end else if (waiting_ff >= COUNT_W'(QUEUE_DEPTH)) begin
                        ev_kind = EV_ERROR;
                     end else begin
                        ring_we    = 1'b1;
                        waiting_in = waiting_ff + COUNT_W'(1);
                        ev_kind    = EV_QUEUED;
                     end
                  end
                  CMD_DISPATCH: begin
                     if (waiting_ff == '0) begin
                        ev_kind = EV_EMPTY;
                     end else if (busy_ff >= cfg.worker_count) begin
                        ev_kind = EV_ERROR;
                     end else begin
                        head_in    = head_ff + INDEX_W'(1);
                        waiting_in = waiting_ff - COUNT_W'(1);
                        busy_in    = busy_ff + COUNT_W'(1);
                        ev_kind    = EV_DISPATCHED;
                        ev_tag     = rd_data;
                     end
                  end
                  CMD_COMPLETE: begin
                     if (busy_ff == '0) begin
                        ev_kind = EV_ERROR;
                     end else begin
                        busy_in = busy_ff - COUNT_W'(1);
                        ev_kind = EV_DONE;
                     end
                  end
                  default: begin
                     ev_kind = EV_ERROR;
                  end
               endcase
            end
         end
         ST_EVICT: begin
            if (out_free) begin
               emit       = 1'b1;
               head_in    = head_ff + INDEX_W'(1);
               waiting_in = waiting_ff - COUNT_W'(1);
               left_in    = left_ff - COUNT_W'(1);
               ev_kind    = EV_EVICTED;
               ev_tag     = rd_data;
               ev_last    = 1'b0;
               if (left_ff == COUNT_W'(1)) begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_PUSH: begin
            if (out_free) begin
               emit       = 1'b1;
               ring_we    = 1'b1;
               waiting_in = waiting_ff + COUNT_W'(1);
               ev_kind    = EV_QUEUED;
               ev_tag     = tag_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         waiting_ff   <= '0;
         busy_ff      <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         waiting_ff   <= waiting_in;
         busy_ff      <= busy_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         cmd_ff <= req_chan.cmd;
         tag_ff <= req_chan.conn_tag;
      end
      if (emit) begin
         kind_ff        <= ev_kind;
         out_tag_ff     <= ev_tag;
         waiting_now_ff <= waiting_in;
         busy_now_ff    <= busy_in;
         last_ff        <= ev_last;
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_kind  = kind_ff;
   assign rsp_chan.out_tag     = out_tag_ff;
   assign rsp_chan.waiting_now = waiting_now_ff;
   assign rsp_chan.busy_now    = busy_now_ff;
   assign rsp_chan.last        = last_ff;

   assign ring_ctl.we    = ring_we;
   assign ring_ctl.waddr = head_ff + waiting_ff[INDEX_W-1:0];
   assign ring_ctl.wdata = tag_ff;
   assign ring_ctl.raddr = head_in;

   assign status.waiting = waiting_ff;
   assign status.busy    = busy_ff;

endmodule

@@ design/request_queue_overload_policy.sv @@
// Top level of the request queue overload policy block with its control registers.
//
// Requests arrive on req_chan as a command (arrival, dispatch, completion) and a
// connection tag. Each request transaction produces one or more response
// transactions on rsp_chan; the final one of a request carries last.
// An arrival is queued, dropped, answered with retry or error, or, when the
// server is full under drop-head or drop-half, first evicts the oldest waiting tags.
// Waiting tags live in a 16-entry ring memory with registered read data.
// One request is accepted and the ring head read in the idle state; the engine
// then decides and loads the response register in the execute state. A drop-head
// arrival then queues its tag in the push state. A drop-half arrival evicts its
// first tag in the execute state and the rest in the evict state, one response
// per tag, before queuing its tag in the push state. A new
// request is taken once the previous one has handed its last response to the
// output register, while that response may still wait to be taken.
// A stalled receiver holds the response register and the engine waits.
// Synchronous reset empties the queue, clears the busy count and restores
// queue_limit 16, overload_mode block and worker_count 4; ring contents are
// not cleared. The csr port writes a register at each clock with the enable
// high and should only be used while no request is in flight.
module request_queue_overload_policy (
   input  logic                            clock,
   input  logic                            reset,
   rqop_req_if.sink                        req_chan,
   rqop_rsp_if.source                      rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [rqop_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rqop_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import rqop_pkg::*;

   cfg_type          cfg_ff;
   ring_ctl_type     ring_ctl;
   status_type       status;
   logic [TAG_W-1:0] rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.queue_limit   <= QUEUE_LIMIT_RESET;
         cfg_ff.overload_mode <= MODE_RESET;
         cfg_ff.worker_count  <= WORKER_COUNT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_QUEUE_LIMIT:   cfg_ff.queue_limit   <= csr_write_data;
            CSR_OVERLOAD_MODE: cfg_ff.overload_mode <= csr_write_data[MODE_W-1:0];
            CSR_WORKER_COUNT:  cfg_ff.worker_count  <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   rqop_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .ring_ctl (ring_ctl),
      .rd_data  (rd_data),
      .status   (status)
   );

   rqop_tag_ring u_ring (
      .clock    (clock),
      .ring_ctl (ring_ctl),
      .rd_data  (rd_data)
   );

   a_waiting_bound: assert property (@(posedge clock) disable iff (reset)
      status.waiting <= COUNT_W'(QUEUE_DEPTH))
      else $error("waiting count exceeds ring depth");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while previous one is still in progress");

   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.we |-> !req_chan.ready)
      else $error("ring written while engine is idle");

   a_response_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> $stable(status))
      else $error("queue counters changed while response is stalled");

endmodule
